[hdl/tsc_pkg.sv]
`default_nettype none

package tsc_pkg;

    localparam int TextBytes = 65536;
    localparam logic [15:0] OffsetMax =
        (TextBytes - 1 < 65535) ? 16'(TextBytes - 1) : 16'hFFFF;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_OP,
        MODE_WORD,
        MODE_NUM,
        MODE_DOT,
        MODE_CHAR1,
        MODE_CHAR2,
        MODE_STR
    } scan_mode_t;

    typedef enum logic [5:0] {
        KIND_EOF,
        KIND_ERROR,
        KIND_LET,
        KIND_VAR,
        KIND_TRUE,
        KIND_FALSE,
        KIND_IDENT,
        KIND_INT,
        KIND_FLOAT,
        KIND_STRING,
        KIND_CHAR,
        KIND_SEMI,
        KIND_LPAREN,
        KIND_RPAREN,
        KIND_LBRACE,
        KIND_RBRACE,
        KIND_ASSIGN,
        KIND_EQ,
        KIND_PLUS,
        KIND_PLUS_EQ,
        KIND_INC,
        KIND_MINUS,
        KIND_MINUS_EQ,
        KIND_DEC,
        KIND_STAR,
        KIND_STAR_EQ,
        KIND_SLASH,
        KIND_SLASH_EQ,
        KIND_PERCENT,
        KIND_PERCENT_EQ,
        KIND_LT,
        KIND_LE,
        KIND_GT,
        KIND_GE
    } token_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_CHAR,
        ERR_STRING,
        ERR_UNEXPECTED
    } error_kind_t;

    typedef struct packed {
        token_kind_t kind;
        error_kind_t err;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
    } token_t;

    typedef struct packed {
        token_t tok_a;
        token_t tok_b;
        logic   a_valid;
        logic   b_valid;
    } entry_t;

endpackage

`default_nettype wire

[hdl/tsc_if.sv]
`default_nettype none

interface tsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

interface tsc_token_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [1:0]  error_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;

    modport source (output valid, output token_kind, output error_kind, output start_offset,
                    output token_length, output line_number, output last_of_run,
                    input ready);
    modport sink (input valid, input token_kind, input error_kind, input start_offset,
                  input token_length, input line_number, input last_of_run,
                  output ready);
endinterface

interface tsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] first_line;

    modport source (output valid, output first_line, input ready);
    modport sink (input valid, input first_line, output ready);
endinterface

`default_nettype wire

[hdl/token_scanner_top.sv]
// A byte's tokens pass a queue entry, hold_reg and out_reg before they are offered.
// Throughput: one byte per cycle while the queue has room; a byte that closes one
// token and emits another yields two tokens, sent in turn via the output register.
// The four-entry queue between scanner and token sender absorbs those bursts.
// Reset: scanner idle, offsets zero, line count and first line register at 1,
// queue and output empty.
`default_nettype none

module token_scanner_top (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tsc_cfg_if.sink      cfg,
    tsc_byte_if.sink     text,
    tsc_token_if.source  tokens
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    tsc_pkg::entry_t push_entry;
    tsc_pkg::entry_t head;

    tsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .text       (text),
        .queue_full (full),
        .push       (push),
        .entry      (push_entry)
    );

    tsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (head),
        .empty      (empty)
    );

    tsc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (head),
        .pop    (pop),
        .tokens (tokens)
    );

endmodule

`default_nettype wire

[hdl/tsc_front.sv]
`default_nettype none

module tsc_front (
    input  wire logic      clk,
    input  wire logic      rst_n,
    tsc_cfg_if.sink        cfg,
    tsc_byte_if.sink       text,
    input  wire logic      queue_full,
    output logic           push,
    output tsc_pkg::entry_t entry
);

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_D0      = 8'h30;
    localparam logic [7:0] CH_D9      = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UZ      = 8'h5A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LZ      = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    localparam logic [2:0] OP_PLUS  = 3'd1;
    localparam logic [2:0] OP_MINUS = 3'd2;

    localparam logic [39:0] WORD_LET   = 40'h00_006C_6574;
    localparam logic [39:0] WORD_VAR   = 40'h00_0076_6172;
    localparam logic [39:0] WORD_TRUE  = 40'h00_7472_7565;
    localparam logic [39:0] WORD_FALSE = 40'h66_616C_7365;

    function automatic tsc_pkg::token_kind_t op_single(input logic [2:0] p);
        tsc_pkg::token_kind_t k;
        case (p)
            3'd0:    k = tsc_pkg::KIND_ASSIGN;
            3'd1:    k = tsc_pkg::KIND_PLUS;
            3'd2:    k = tsc_pkg::KIND_MINUS;
            3'd3:    k = tsc_pkg::KIND_STAR;
            3'd4:    k = tsc_pkg::KIND_SLASH;
            3'd5:    k = tsc_pkg::KIND_PERCENT;
            3'd6:    k = tsc_pkg::KIND_LT;
            default: k = tsc_pkg::KIND_GT;
        endcase
        return k;
    endfunction

    function automatic tsc_pkg::token_kind_t op_with_eq(input logic [2:0] p);
        tsc_pkg::token_kind_t k;
        case (p)
            3'd0:    k = tsc_pkg::KIND_EQ;
            3'd1:    k = tsc_pkg::KIND_PLUS_EQ;
            3'd2:    k = tsc_pkg::KIND_MINUS_EQ;
            3'd3:    k = tsc_pkg::KIND_STAR_EQ;
            3'd4:    k = tsc_pkg::KIND_SLASH_EQ;
            3'd5:    k = tsc_pkg::KIND_PERCENT_EQ;
            3'd6:    k = tsc_pkg::KIND_LE;
            default: k = tsc_pkg::KIND_GE;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CH_D0) && (ch <= CH_D9);
    endfunction

    function automatic logic is_word(input logic [7:0] ch);
        return ((ch >= CH_LA) && (ch <= CH_LZ)) || ((ch >= CH_UA) && (ch <= CH_UZ))
            || is_digit(ch) || (ch == CH_UNDER);
    endfunction

    tsc_pkg::scan_mode_t mode_reg, mode_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] first_line_reg;
    logic [2:0]  pend_reg, pend_next;
    logic [39:0] prefix_reg, prefix_next;
    logic        dot_reg, dot_next;

    logic        accept;
    logic [7:0]  ch;
    logic [15:0] span;
    logic [15:0] inner;
    logic        fresh;
    logic        restart;
    logic        bump;
    logic        op_hit;
    logic [2:0]  op_idx;
    tsc_pkg::token_t tok_a, tok_b;
    logic        a_valid, b_valid;

    assign ch     = text.char_code;
    assign accept = text.valid && text.ready;
    assign span   = (offset_reg > start_reg) ? offset_reg - start_reg : 16'd0;
    assign inner  = (start_reg != 16'hFFFF) ? start_reg + 16'd1 : 16'hFFFF;

    always_comb
    begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        offset_next = offset_reg;
        line_next   = line_reg;
        pend_next   = pend_reg;
        prefix_next = prefix_reg;
        dot_next    = dot_reg;
        tok_a       = '0;
        tok_b       = '0;
        tok_a.line  = line_reg;
        tok_b.line  = line_reg;
        a_valid     = 1'b0;
        b_valid     = 1'b0;
        fresh       = 1'b0;
        restart     = 1'b0;
        bump        = 1'b0;
        op_hit      = 1'b0;
        op_idx      = 3'd0;

        unique case (mode_reg)
            tsc_pkg::MODE_OP:
            begin
                a_valid     = 1'b1;
                tok_a.start = start_reg;
                tok_a.len   = 16'd2;
                mode_next   = tsc_pkg::MODE_IDLE;
                if (ch == CH_EQ) begin
                    tok_a.kind = op_with_eq(pend_reg);
                end else if (ch == CH_PLUS && pend_reg == OP_PLUS) begin
                    tok_a.kind = tsc_pkg::KIND_INC;
                end else if (ch == CH_MINUS && pend_reg == OP_MINUS) begin
                    tok_a.kind = tsc_pkg::KIND_DEC;
                end else begin
                    tok_a.kind = op_single(pend_reg);
                    tok_a.len  = 16'd1;
                    fresh      = 1'b1;
                end
            end
            tsc_pkg::MODE_WORD:
            begin
                if (is_word(ch)) begin
                    prefix_next = {prefix_reg[31:0], ch};
                end else begin
                    a_valid     = 1'b1;
                    tok_a.start = start_reg;
                    tok_a.len   = span;
                    if (span == 16'd3 && prefix_reg == WORD_LET) begin
                        tok_a.kind = tsc_pkg::KIND_LET;
                    end else if (span == 16'd3 && prefix_reg == WORD_VAR) begin
                        tok_a.kind = tsc_pkg::KIND_VAR;
                    end else if (span == 16'd4 && prefix_reg == WORD_TRUE) begin
                        tok_a.kind = tsc_pkg::KIND_TRUE;
                    end else if (span == 16'd5 && prefix_reg == WORD_FALSE) begin
                        tok_a.kind = tsc_pkg::KIND_FALSE;
                    end else begin
                        tok_a.kind = tsc_pkg::KIND_IDENT;
                    end
                    fresh = 1'b1;
                end
            end
            tsc_pkg::MODE_NUM:
            begin
                if (ch == CH_DOT) begin
                    dot_next = 1'b1;
                end else if (!is_digit(ch)) begin
                    a_valid     = 1'b1;
                    tok_a.kind  = dot_reg ? tsc_pkg::KIND_FLOAT : tsc_pkg::KIND_INT;
                    tok_a.start = start_reg;
                    tok_a.len   = span;
                    fresh       = 1'b1;
                end
            end
            tsc_pkg::MODE_DOT:
            begin
                if (is_digit(ch)) begin
                    mode_next = tsc_pkg::MODE_NUM;
                    dot_next  = 1'b1;
                end else begin
                    a_valid     = 1'b1;
                    tok_a.kind  = tsc_pkg::KIND_ERROR;
                    tok_a.err   = tsc_pkg::ERR_UNEXPECTED;
                    tok_a.start = start_reg;
                    tok_a.len   = 16'd1;
                    fresh       = 1'b1;
                end
            end
            tsc_pkg::MODE_CHAR1:
            begin
                if (ch == CH_NUL) begin
                    a_valid     = 1'b1;
                    tok_a.kind  = tsc_pkg::KIND_ERROR;
                    tok_a.err   = tsc_pkg::ERR_CHAR;
                    tok_a.start = start_reg;
                    tok_a.len   = span;
                    fresh       = 1'b1;
                end else begin
                    mode_next = tsc_pkg::MODE_CHAR2;
                end
            end
            tsc_pkg::MODE_CHAR2:
            begin
                a_valid = 1'b1;
                if (ch == CH_SQUOTE) begin
                    tok_a.kind  = tsc_pkg::KIND_CHAR;
                    tok_a.start = inner;
                    tok_a.len   = 16'd1;
                    mode_next   = tsc_pkg::MODE_IDLE;
                end else begin
                    tok_a.kind  = tsc_pkg::KIND_ERROR;
                    tok_a.err   = tsc_pkg::ERR_CHAR;
                    tok_a.start = start_reg;
                    tok_a.len   = span;
                    fresh       = 1'b1;
                end
            end
            tsc_pkg::MODE_STR:
            begin
                if (ch == CH_DQUOTE) begin
                    a_valid     = 1'b1;
                    tok_a.kind  = tsc_pkg::KIND_STRING;
                    tok_a.start = inner;
                    tok_a.len   = (span != 16'd0) ? span - 16'd1 : 16'd0;
                    mode_next   = tsc_pkg::MODE_IDLE;
                end else if (ch == CH_NUL) begin
                    a_valid     = 1'b1;
                    tok_a.kind  = tsc_pkg::KIND_ERROR;
                    tok_a.err   = tsc_pkg::ERR_STRING;
                    tok_a.start = start_reg;
                    tok_a.len   = span;
                    fresh       = 1'b1;
                end else if (ch == CH_LF) begin
                    bump = 1'b1;
                end
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase

        // rescan the current byte from idle
        if (fresh) begin
            mode_next   = tsc_pkg::MODE_IDLE;
            tok_b.start = offset_reg;
            tok_b.len   = 16'd1;
            case (ch) inside
                CH_NUL:
                begin
                    b_valid    = 1'b1;
                    tok_b.kind = tsc_pkg::KIND_EOF;
                    tok_b.len  = 16'd0;
                    restart    = 1'b1;
                end
                CH_SPACE, CH_CR, CH_TAB: ;
                CH_LF:     bump = 1'b1;
                CH_SEMI:   begin b_valid = 1'b1; tok_b.kind = tsc_pkg::KIND_SEMI;   end
                CH_LPAREN: begin b_valid = 1'b1; tok_b.kind = tsc_pkg::KIND_LPAREN; end
                CH_RPAREN: begin b_valid = 1'b1; tok_b.kind = tsc_pkg::KIND_RPAREN; end
                CH_LBRACE: begin b_valid = 1'b1; tok_b.kind = tsc_pkg::KIND_LBRACE; end
                CH_RBRACE: begin b_valid = 1'b1; tok_b.kind = tsc_pkg::KIND_RBRACE; end
                CH_EQ:      begin op_hit = 1'b1; op_idx = 3'd0; end
                CH_PLUS:    begin op_hit = 1'b1; op_idx = 3'd1; end
                CH_MINUS:   begin op_hit = 1'b1; op_idx = 3'd2; end
                CH_STAR:    begin op_hit = 1'b1; op_idx = 3'd3; end
                CH_SLASH:   begin op_hit = 1'b1; op_idx = 3'd4; end
                CH_PERCENT: begin op_hit = 1'b1; op_idx = 3'd5; end
                CH_LT:      begin op_hit = 1'b1; op_idx = 3'd6; end
                CH_GT:      begin op_hit = 1'b1; op_idx = 3'd7; end
                CH_SQUOTE:
                begin
                    start_next = offset_reg;
                    mode_next  = tsc_pkg::MODE_CHAR1;
                end
                CH_DQUOTE:
                begin
                    start_next = offset_reg;
                    mode_next  = tsc_pkg::MODE_STR;
                end
                [CH_D0:CH_D9]:
                begin
                    start_next = offset_reg;
                    mode_next  = tsc_pkg::MODE_NUM;
                    dot_next   = 1'b0;
                end
                CH_DOT:
                begin
                    start_next = offset_reg;
                    mode_next  = tsc_pkg::MODE_DOT;
                end
                [CH_LA:CH_LZ], [CH_UA:CH_UZ], CH_UNDER:
                begin
                    start_next  = offset_reg;
                    mode_next   = tsc_pkg::MODE_WORD;
                    prefix_next = {32'd0, ch};
                end
                default:
                begin
                    start_next = offset_reg;
                    b_valid    = 1'b1;
                    tok_b.kind = tsc_pkg::KIND_ERROR;
                    tok_b.err  = tsc_pkg::ERR_UNEXPECTED;
                end
            endcase
            if (op_hit) begin
                start_next = offset_reg;
                mode_next  = tsc_pkg::MODE_OP;
                pend_next  = op_idx;
            end
        end

        if (bump && line_reg != 16'hFFFF) begin
            line_next = line_reg + 16'd1;
        end

        if (restart) begin
            mode_next   = tsc_pkg::MODE_IDLE;
            start_next  = '0;
            offset_next = '0;
            line_next   = first_line_reg;
            pend_next   = '0;
            prefix_next = '0;
            dot_next    = 1'b0;
        end else if (offset_reg < tsc_pkg::OffsetMax) begin
            offset_next = offset_reg + 16'd1;
        end
    end

    assign text.ready    = !queue_full;
    assign cfg.ready     = 1'b1;
    assign push          = accept && (a_valid || b_valid);
    assign entry.tok_a   = tok_a;
    assign entry.tok_b   = tok_b;
    assign entry.a_valid = a_valid;
    assign entry.b_valid = b_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= tsc_pkg::MODE_IDLE;
            start_reg      <= '0;
            offset_reg     <= '0;
            line_reg       <= 16'd1;
            first_line_reg <= 16'd1;
            pend_reg       <= '0;
            prefix_reg     <= '0;
            dot_reg        <= 1'b0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                first_line_reg <= cfg.first_line;
            end
            if (accept) begin
                mode_reg   <= mode_next;
                start_reg  <= start_next;
                offset_reg <= offset_next;
                line_reg   <= line_next;
                pend_reg   <= pend_next;
                prefix_reg <= prefix_next;
                dot_reg    <= dot_next;
            end else if (cfg.valid && cfg.ready && offset_reg == 16'd0
                         && mode_reg == tsc_pkg::MODE_IDLE) begin
                line_reg <= cfg.first_line;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/tsc_queue.sv]
`default_nettype none

module tsc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire tsc_pkg::entry_t  push_entry,
    output logic                  full,
    input  wire logic             pop,
    output tsc_pkg::entry_t       pop_entry,
    output logic                  empty
);

    tsc_pkg::entry_t mem [tsc_pkg::QueueDepth];

    logic [tsc_pkg::QueuePtrW-1:0] wr_ptr_reg;
    logic [tsc_pkg::QueuePtrW-1:0] rd_ptr_reg;
    logic [tsc_pkg::QueuePtrW:0]   count_reg, count_next;

    assign full      = (count_reg == (tsc_pkg::QueuePtrW + 1)'(tsc_pkg::QueueDepth));
    assign empty     = (count_reg == '0);
    assign pop_entry = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (tsc_pkg::QueuePtrW + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (tsc_pkg::QueuePtrW + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + (tsc_pkg::QueuePtrW)'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + (tsc_pkg::QueuePtrW)'(1);
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (tsc_pkg::QueuePtrW + 1)'(tsc_pkg::QueueDepth))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + (tsc_pkg::QueuePtrW + 1)'(1)))
        else $error("count did not advance on push");

    a_items_valid: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_entry.a_valid || push_entry.b_valid))
        else $error("empty entry pushed");

endmodule

`default_nettype wire

[hdl/tsc_back.sv]
`default_nettype none

module tsc_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             empty,
    input  wire tsc_pkg::entry_t  head,
    output logic                  pop,
    tsc_token_if.source           tokens
);

    tsc_pkg::entry_t hold_reg;
    logic            hold_a_reg;
    logic            hold_b_reg;
    tsc_pkg::token_t out_reg;
    logic            out_last_reg;
    logic            out_valid_reg;

    logic            out_free;
    logic            take;
    logic            rem_a;
    logic            rem_b;
    tsc_pkg::token_t sel_tok;
    logic            sel_last;

    assign out_free = !out_valid_reg || tokens.ready;
    assign take     = out_free && (hold_a_reg || hold_b_reg);
    assign rem_a    = hold_a_reg && !take;
    assign rem_b    = hold_b_reg && !(take && !hold_a_reg);
    assign sel_tok  = hold_a_reg ? hold_reg.tok_a : hold_reg.tok_b;
    assign sel_last = hold_a_reg ? !hold_b_reg : 1'b1;
    assign pop      = !empty && !rem_a && !rem_b;

    assign tokens.valid        = out_valid_reg;
    assign tokens.token_kind   = out_reg.kind;
    assign tokens.error_kind   = out_reg.err;
    assign tokens.start_offset = out_reg.start;
    assign tokens.token_length = out_reg.len;
    assign tokens.line_number  = out_reg.line;
    assign tokens.last_of_run  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_a_reg    <= 1'b0;
            hold_b_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                hold_a_reg <= head.a_valid;
                hold_b_reg <= head.b_valid;
            end else begin
                hold_a_reg <= rem_a;
                hold_b_reg <= rem_b;
            end
            if (take) begin
                out_valid_reg <= 1'b1;
            end else if (tokens.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            hold_reg <= head;
        end
        if (take) begin
            out_reg      <= sel_tok;
            out_last_reg <= sel_last;
        end
    end

endmodule

`default_nettype wire

[test/tb_token_scanner_top.sv]
`timescale 1ns / 100ps

module tb_token_scanner_top;

    localparam int CYCLE_LIMIT = 50000;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASE_BYTES = 250;
    localparam int HOLD_CYCLES = 400;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [15:0] LINE_MAX = 16'hFFFF;

    localparam string WORD_CHARS =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    localparam string OP_CHARS = "=+-*/%<>";
    localparam string PUNCT_CHARS = ";(){}";
    localparam string BLANK_CHARS = " \t\n";

    typedef struct packed {
        tsc_pkg::token_kind_t kind;
        tsc_pkg::error_kind_t err;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } token_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tsc_cfg_if   cfg_bus ();
    tsc_byte_if  byte_bus ();
    tsc_token_if token_bus ();

    token_scanner_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .text   (byte_bus),
        .tokens (token_bus)
    );

    logic [7:0] byte_q[$];
    token_rec_t expected_tokens[$];
    token_rec_t run_toks[$];
    token_rec_t got_exp;

    tsc_pkg::scan_mode_t mode;
    logic [15:0] tok_start;
    logic [15:0] byte_off;
    logic [15:0] line_cnt;
    logic [15:0] text_first_line;
    logic [7:0]  pend_char;
    logic [39:0] kw_prefix;
    logic        dot_seen;
    logic        restart;

    int   send_idle_pct = 0;
    int   stall_pct = 0;
    logic hold_start = 1'b0;
    int   hold_left = 0;

    int n_errors = 0;
    int n_bytes = 0;
    int n_texts = 0;
    int n_checked = 0;
    int n_settings = 0;
    int cycle_count = 0;

    string word_pool [10] = '{"let", "var", "true", "false", "le", "lets", "tru",
                              "falsey", "var_", "_x9"};

    always #4 clk = ~clk;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [15:0] span(input logic [15:0] off);
        return (off > tok_start) ? off - tok_start : 16'd0;
    endfunction

    function automatic logic [15:0] inner_start();
        return (tok_start < LINE_MAX) ? tok_start + 16'd1 : LINE_MAX;
    endfunction

    function automatic void bump_line();
        if (line_cnt < LINE_MAX)
        begin
            line_cnt++;
        end
    endfunction

    function automatic void restart_text();
        mode = tsc_pkg::MODE_IDLE;
        tok_start = '0;
        byte_off = '0;
        line_cnt = text_first_line;
        pend_char = '0;
        kw_prefix = '0;
        dot_seen = 1'b0;
    endfunction

    function automatic tsc_pkg::token_kind_t op_kind(input logic [7:0] op,
                                                     input logic with_eq);
        case (op)
            "=": return with_eq ? tsc_pkg::KIND_EQ : tsc_pkg::KIND_ASSIGN;
            "+": return with_eq ? tsc_pkg::KIND_PLUS_EQ : tsc_pkg::KIND_PLUS;
            "-": return with_eq ? tsc_pkg::KIND_MINUS_EQ : tsc_pkg::KIND_MINUS;
            "*": return with_eq ? tsc_pkg::KIND_STAR_EQ : tsc_pkg::KIND_STAR;
            "/": return with_eq ? tsc_pkg::KIND_SLASH_EQ : tsc_pkg::KIND_SLASH;
            "%": return with_eq ? tsc_pkg::KIND_PERCENT_EQ : tsc_pkg::KIND_PERCENT;
            "<": return with_eq ? tsc_pkg::KIND_LE : tsc_pkg::KIND_LT;
            default: return with_eq ? tsc_pkg::KIND_GE : tsc_pkg::KIND_GT;
        endcase
    endfunction

    function automatic void emit_token(input tsc_pkg::token_kind_t kind,
                                       input tsc_pkg::error_kind_t err,
                                       input logic [15:0] start, input logic [15:0] len);
        token_rec_t t;
        if (run_toks.size() >= 2)
        begin
            return;
        end
        t.kind = kind;
        t.err = err;
        t.start = start;
        t.len = len;
        t.line = line_cnt;
        t.last = 1'b0;
        run_toks.push_back(t);
    endfunction

    function automatic void scan_fresh(input logic [7:0] c, input logic [15:0] off);
        mode = tsc_pkg::MODE_IDLE;
        case (c)
            CH_NUL:
            begin
                emit_token(tsc_pkg::KIND_EOF, tsc_pkg::ERR_NONE, off, 16'd0);
                restart = 1'b1;
            end
            " ", CH_CR, CH_TAB: ;
            CH_LF: bump_line();
            ";": emit_token(tsc_pkg::KIND_SEMI, tsc_pkg::ERR_NONE, off, 16'd1);
            "(": emit_token(tsc_pkg::KIND_LPAREN, tsc_pkg::ERR_NONE, off, 16'd1);
            ")": emit_token(tsc_pkg::KIND_RPAREN, tsc_pkg::ERR_NONE, off, 16'd1);
            "{": emit_token(tsc_pkg::KIND_LBRACE, tsc_pkg::ERR_NONE, off, 16'd1);
            "}": emit_token(tsc_pkg::KIND_RBRACE, tsc_pkg::ERR_NONE, off, 16'd1);
            "=", "+", "-", "*", "/", "%", "<", ">":
            begin
                mode = tsc_pkg::MODE_OP;
                pend_char = c;
                tok_start = off;
            end
            "'":
            begin
                tok_start = off;
                mode = tsc_pkg::MODE_CHAR1;
            end
            "\"":
            begin
                tok_start = off;
                mode = tsc_pkg::MODE_STR;
            end
            ".":
            begin
                tok_start = off;
                mode = tsc_pkg::MODE_DOT;
            end
            default:
            begin
                tok_start = off;
                if (is_digit(c))
                begin
                    mode = tsc_pkg::MODE_NUM;
                    dot_seen = 1'b0;
                end
                else if (is_word_start(c))
                begin
                    mode = tsc_pkg::MODE_WORD;
                    kw_prefix = {32'd0, c};
                end
                else
                begin
                    emit_token(tsc_pkg::KIND_ERROR, tsc_pkg::ERR_UNEXPECTED, off, 16'd1);
                end
            end
        endcase
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        logic [15:0] off;
        logic [15:0] len;
        tsc_pkg::token_kind_t kind;
        off = byte_off;
        run_toks.delete();
        restart = 1'b0;
        case (mode)
            tsc_pkg::MODE_OP:
            begin
                if (c == "=")
                begin
                    emit_token(op_kind(pend_char, 1'b1), tsc_pkg::ERR_NONE, tok_start, 16'd2);
                    mode = tsc_pkg::MODE_IDLE;
                end
                else if (c == "+" && pend_char == "+")
                begin
                    emit_token(tsc_pkg::KIND_INC, tsc_pkg::ERR_NONE, tok_start, 16'd2);
                    mode = tsc_pkg::MODE_IDLE;
                end
                else if (c == "-" && pend_char == "-")
                begin
                    emit_token(tsc_pkg::KIND_DEC, tsc_pkg::ERR_NONE, tok_start, 16'd2);
                    mode = tsc_pkg::MODE_IDLE;
                end
                else
                begin
                    emit_token(op_kind(pend_char, 1'b0), tsc_pkg::ERR_NONE, tok_start, 16'd1);
                    scan_fresh(c, off);
                end
            end
            tsc_pkg::MODE_WORD:
            begin
                if (is_word_start(c) || is_digit(c))
                begin
                    kw_prefix = {kw_prefix[31:0], c};
                end
                else
                begin
                    len = span(off);
                    kind = tsc_pkg::KIND_IDENT;
                    if (len == 16'd3 && kw_prefix == "let")
                        kind = tsc_pkg::KIND_LET;
                    else if (len == 16'd3 && kw_prefix == "var")
                        kind = tsc_pkg::KIND_VAR;
                    else if (len == 16'd4 && kw_prefix == "true")
                        kind = tsc_pkg::KIND_TRUE;
                    else if (len == 16'd5 && kw_prefix == "false")
                        kind = tsc_pkg::KIND_FALSE;
                    emit_token(kind, tsc_pkg::ERR_NONE, tok_start, len);
                    scan_fresh(c, off);
                end
            end
            tsc_pkg::MODE_NUM:
            begin
                if (c == ".")
                begin
                    dot_seen = 1'b1;
                end
                else if (!is_digit(c))
                begin
                    emit_token(dot_seen ? tsc_pkg::KIND_FLOAT : tsc_pkg::KIND_INT,
                               tsc_pkg::ERR_NONE, tok_start, span(off));
                    scan_fresh(c, off);
                end
            end
            tsc_pkg::MODE_DOT:
            begin
                if (is_digit(c))
                begin
                    mode = tsc_pkg::MODE_NUM;
                    dot_seen = 1'b1;
                end
                else
                begin
                    emit_token(tsc_pkg::KIND_ERROR, tsc_pkg::ERR_UNEXPECTED, tok_start, 16'd1);
                    scan_fresh(c, off);
                end
            end
            tsc_pkg::MODE_CHAR1:
            begin
                if (c == CH_NUL)
                begin
                    emit_token(tsc_pkg::KIND_ERROR, tsc_pkg::ERR_CHAR, tok_start, span(off));
                    scan_fresh(c, off);
                end
                else
                begin
                    mode = tsc_pkg::MODE_CHAR2;
                end
            end
            tsc_pkg::MODE_CHAR2:
            begin
                if (c == "'")
                begin
                    emit_token(tsc_pkg::KIND_CHAR, tsc_pkg::ERR_NONE, inner_start(), 16'd1);
                    mode = tsc_pkg::MODE_IDLE;
                end
                else
                begin
                    emit_token(tsc_pkg::KIND_ERROR, tsc_pkg::ERR_CHAR, tok_start, span(off));
                    scan_fresh(c, off);
                end
            end
            tsc_pkg::MODE_STR:
            begin
                if (c == "\"")
                begin
                    len = span(off);
                    emit_token(tsc_pkg::KIND_STRING, tsc_pkg::ERR_NONE, inner_start(),
                               (len > 16'd0) ? len - 16'd1 : 16'd0);
                    mode = tsc_pkg::MODE_IDLE;
                end
                else if (c == CH_NUL)
                begin
                    emit_token(tsc_pkg::KIND_ERROR, tsc_pkg::ERR_STRING, tok_start, span(off));
                    scan_fresh(c, off);
                end
                else if (c == CH_LF)
                begin
                    bump_line();
                end
            end
            default: scan_fresh(c, off);
        endcase

        if (restart)
        begin
            restart_text();
            n_texts++;
        end
        else if (byte_off < tsc_pkg::OffsetMax)
        begin
            byte_off++;
        end

        if (run_toks.size() > 0)
        begin
            run_toks[run_toks.size() - 1].last = 1'b1;
        end
        foreach (run_toks[k])
        begin
            expected_tokens.push_back(run_toks[k]);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    function automatic void push_text(input string s);
        foreach (s[i])
        begin
            byte_q.push_back(s[i]);
        end
    endfunction

    function automatic logic [7:0] rand_digit();
        return "0" + 8'($urandom_range(9));
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_bus.valid && byte_bus.ready)
            begin
                scan_byte(byte_bus.char_code);
                n_bytes++;
            end
            if (!byte_bus.valid || byte_bus.ready)
            begin
                if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    byte_bus.valid <= 1'b1;
                    byte_bus.char_code <= byte_q.pop_front();
                end
                else
                begin
                    byte_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (token_bus.valid && token_bus.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("token with no expectation: kind %0d start %0d",
                           token_bus.token_kind, token_bus.start_offset);
                    n_errors++;
                end
                else
                begin
                    got_exp = expected_tokens.pop_front();
                    check_field("token_kind", got_exp.kind, token_bus.token_kind);
                    check_field("error_kind", got_exp.err, token_bus.error_kind);
                    check_field("start_offset", got_exp.start, token_bus.start_offset);
                    check_field("token_length", got_exp.len, token_bus.token_length);
                    check_field("line_number", got_exp.line, token_bus.line_number);
                    check_field("last_of_run", got_exp.last, token_bus.last_of_run);
                    n_checked++;
                end
            end
            token_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (byte_q.size() != 0 || byte_bus.valid || expected_tokens.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic set_first_line(input logic [15:0] value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.first_line <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        text_first_line = value;
        if (byte_off == 16'd0 && mode == tsc_pkg::MODE_IDLE)
        begin
            line_cnt = value;
        end
        n_settings++;
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall);
        int pick;
        logic [7:0] b;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        while (byte_q.size() < PHASE_BYTES)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                push_text(word_pool[$urandom_range(9)]);
            end
            else if (pick < 22)
            begin
                byte_q.push_back(WORD_CHARS[$urandom_range(52)]);
                repeat ($urandom_range(7)) byte_q.push_back(WORD_CHARS[$urandom_range(62)]);
            end
            else if (pick < 32)
            begin
                if ($urandom_range(3) == 0)
                    byte_q.push_back(".");
                byte_q.push_back(rand_digit());
                repeat ($urandom_range(3)) byte_q.push_back(rand_digit());
                if ($urandom_range(2) == 0)
                begin
                    byte_q.push_back(".");
                    repeat ($urandom_range(3)) byte_q.push_back(rand_digit());
                end
            end
            else if (pick < 50)
            begin
                b = OP_CHARS[$urandom_range(7)];
                byte_q.push_back(b);
                case ($urandom_range(2))
                    0: byte_q.push_back("=");
                    1: byte_q.push_back(b);
                    default: ;
                endcase
            end
            else if (pick < 58)
            begin
                byte_q.push_back(PUNCT_CHARS[$urandom_range(4)]);
            end
            else if (pick < 64)
            begin
                byte_q.push_back("'");
                byte_q.push_back(8'($urandom_range(1, 255)));
                byte_q.push_back("'");
            end
            else if (pick < 70)
            begin
                byte_q.push_back("\"");
                repeat ($urandom_range(6))
                begin
                    b = 8'($urandom_range(1, 255));
                    byte_q.push_back((b == "\"") ? CH_LF : b);
                end
                byte_q.push_back("\"");
            end
            else if (pick < 80)
            begin
                byte_q.push_back(BLANK_CHARS[$urandom_range(2)]);
            end
            else if (pick < 82)
            begin
                byte_q.push_back(CH_CR);
            end
            else if (pick < 88)
            begin
                byte_q.push_back(8'($urandom_range(1, 255)));
            end
            else if (pick < 95)
            begin
                case ($urandom_range(2))
                    0:
                    begin
                        byte_q.push_back("'");
                        byte_q.push_back(8'($urandom_range(1, 255)));
                        byte_q.push_back(8'($urandom_range(1, 255)));
                    end
                    1: byte_q.push_back(".");
                    default:
                    begin
                        byte_q.push_back("\"");
                        repeat ($urandom_range(4)) byte_q.push_back(WORD_CHARS[$urandom_range(62)]);
                        byte_q.push_back(CH_NUL);
                    end
                endcase
            end
            else
            begin
                byte_q.push_back(CH_NUL);
            end
            if (pick < 70 && $urandom_range(1) == 0)
            begin
                byte_q.push_back(" ");
            end
        end
        wait_idle();
    endtask

    initial
    begin
        byte_bus.valid = 1'b0;
        byte_bus.char_code = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.first_line = '0;
        token_bus.ready = 1'b0;
        text_first_line = 16'd1;
        restart_text();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_text("let var true false x_1 12 3.5 .7 . 9.\n");
        push_text("a==b+=c++-=d--*=e/=f%=g<=h>=i=+-*/%<>;(){}\t");
        push_text("'q' 'ab '\n' \"s\nt\" \"\" @");
        byte_q.push_back(CH_CR);
        byte_q.push_back(8'h80);
        byte_q.push_back(8'hFF);
        push_text("x+");
        byte_q.push_back(CH_NUL);
        byte_q.push_back("'");
        byte_q.push_back(CH_NUL);
        push_text("\"ab\n");
        byte_q.push_back(CH_NUL);
        wait_idle();

        set_first_line(16'd0);
        run_random_phase(0, 0);
        set_first_line(16'($urandom_range(2, 65534)));
        run_random_phase(71, 0);
        set_first_line(LINE_MAX);
        run_random_phase(0, 71);
        set_first_line(16'($urandom_range(2, 65534)));
        run_random_phase(33, 33);

        send_idle_pct = 0;
        stall_pct = 0;
        repeat (60) push_text("+;");
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        wait_idle();

        set_first_line(16'd65533);
        byte_q.push_back(CH_NUL);
        push_text("a\nb\n\nc\n\n\nd \"x\ny\" ;");
        byte_q.push_back(CH_NUL);
        wait_idle();

        set_first_line(16'd1);
        push_text("\"lo\nng\" abc 42 'x' \"q\" . +");
        byte_q.push_back(CH_NUL);
        wait_idle();

        $display("Scanned %0d bytes over %0d texts, %0d tokens checked", n_bytes, n_texts,
                 n_checked);
        $display("Covered %0d first-line writes, back-pressure and line-count saturation",
                 n_settings);
        if (n_errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
